/* sv/ccc_pkg.sv */
// Shared types, widths and constants for the circle collision contact pipeline.
package ccc_pkg;

  localparam int CoordW   = 16;
  localparam int NumSteps = 20;
  localparam int DivBits  = 16;
  localparam int PreShift = 14;
  localparam int CordW    = 35;
  localparam int ZW       = 25;
  localparam int RemW     = 34;
  localparam int TotW     = 17;
  localparam int AngW     = 14;

  localparam logic signed [ZW-1:0]  Deg90Q16 = ZW'(5898240);
  localparam logic signed [ZW-1:0]  RoundQ16 = ZW'(2048);
  localparam logic signed [AngW-1:0] DegQ4_90  = AngW'(1440);
  localparam logic signed [AngW-1:0] DegQ4_180 = AngW'(2880);
  localparam logic signed [AngW-1:0] DegQ4_270 = AngW'(4320);

  // atan(2^-i) in degrees, Q16.
  localparam int AtanTab [NumSteps] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  typedef struct packed {
    logic                     touch;
    logic                     zero_total;
    logic                     dx_zero;
    logic                     dx_pos;
    logic                     sign_neg;
    logic                     y1_lt;
    logic [CoordW-1:0]        x1;
    logic [CoordW-1:0]        y1;
    logic [TotW-1:0]          total;
    logic [RemW-1:0]          rem_x;
    logic [RemW-1:0]          rem_y;
    logic [CoordW-1:0]        q_x;
    logic [CoordW-1:0]        q_y;
    logic signed [CordW-1:0]  cx;
    logic signed [CordW-1:0]  cy;
    logic signed [ZW-1:0]     z;
  } ccc_iter_t;

endpackage

/* sv/ccc_iter_stage.sv */
// One stage: one vectoring CORDIC step; below DivBits also one bit of both quotients.
module ccc_iter_stage #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  ccc_pkg::ccc_iter_t in_data,
  output logic              out_valid,
  output ccc_pkg::ccc_iter_t out_data
);
  import ccc_pkg::*;

  localparam int K = (STEP < DivBits) ? (DivBits - 1 - STEP) : 0;
  localparam logic signed [ZW-1:0] Atan = ZW'(AtanTab[STEP]);

  logic               valid_r;
  ccc_iter_t          data_r;
  ccc_iter_t          data_nxt;
  logic signed [CordW-1:0] xs;
  logic signed [CordW-1:0] ys;
  logic [RemW-1:0]    dvs;

  always_comb begin
    data_nxt = in_data;
    // Shifts truncate toward zero; x never goes negative.
    xs = in_data.cx >>> STEP;
    if (in_data.cy[CordW-1]) begin
      ys = -((-in_data.cy) >>> STEP);
    end else begin
      ys = in_data.cy >>> STEP;
    end
    if (!in_data.cy[CordW-1]) begin
      data_nxt.cx = in_data.cx + ys;
      data_nxt.cy = in_data.cy - xs;
      data_nxt.z  = in_data.z + Atan;
    end else begin
      data_nxt.cx = in_data.cx - ys;
      data_nxt.cy = in_data.cy + xs;
      data_nxt.z  = in_data.z - Atan;
    end
    dvs = RemW'(in_data.total) << K;
    if (STEP < DivBits) begin
      if (in_data.rem_x >= dvs) begin
        data_nxt.rem_x = in_data.rem_x - dvs;
        data_nxt.q_x[K] = 1'b1;
      end
      if (in_data.rem_y >= dvs) begin
        data_nxt.rem_y = in_data.rem_y - dvs;
        data_nxt.q_y[K] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
endmodule

/* sv/circle_collision_contact_top.sv */
// Top level of the circle collision contact pipeline.
//
// Input stream in_*: one request per pair of circles. in_tdata carries
// first_x, first_y, first_radius, second_x, second_y, second_radius and
// margin, 16 bits each, unsigned Q12.4, from the lowest bit up.
// Output stream out_*: one result per request, in order. out_tuser is the
// touching flag; out_tdata carries contact_x, contact_y (Q12.4) and the
// signed Q9.4 contact angle in degrees.
// From acceptance to out_tvalid a request passes three setup stages
// (differences, products, distance compare), twenty stages that each run
// one CORDIC step and, in the first sixteen, one quotient bit of the two
// divisions, and the output register. A new request is taken in every
// cycle unless the output stalls; the single-step stages set that rate.
// The whole pipeline advances while the output register is empty or being
// taken, so a stalled receiver holds every stage and in_tready drops.
// Reset clears all valid bits; nothing else is needed after it.
module circle_collision_contact_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // first_x, first_y, first_radius, second_x, second_y, second_radius, margin
  input  logic [111:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // contact_x, contact_y, contact_angle, zero pad
  output logic [47:0]  out_tdata,
  // touching
  output logic         out_tuser
);
  import ccc_pkg::*;

  logic en;

  logic [CoordW-1:0] x1, y1, r1, x2, y2, r2, mg;
  logic signed [CoordW:0] dx, dy;

  // Stage A
  logic              a_valid_r;
  logic [CoordW-1:0] a_x1_r, a_y1_r, a_x2_r, a_y2_r, a_r1_r, a_r2_r, a_adx_r, a_ady_r;
  logic              a_dx_zero_r, a_dx_pos_r, a_sign_neg_r, a_y1_lt_r;
  logic [TotW-1:0]   a_total_r;
  logic [TotW:0]     a_reach_r;

  // Stage B
  logic              b_valid_r;
  logic [31:0]       b_d2a_r, b_d2b_r, b_px_r, b_qx_r, b_py_r, b_qy_r;
  logic [35:0]       b_reach2_r;
  logic [CoordW-1:0] b_x1_r, b_y1_r, b_adx_r, b_ady_r;
  logic              b_dx_zero_r, b_dx_pos_r, b_sign_neg_r, b_y1_lt_r;
  logic [TotW-1:0]   b_total_r;

  // Stage C and the iteration chain
  logic      c_valid_r;
  ccc_iter_t c_data_r, c_data_nxt;
  logic      pipe_valid [NumSteps+1];
  ccc_iter_t pipe_data  [NumSteps+1];

  ccc_iter_t             fin;
  logic signed [ZW-1:0]  zc;
  logic signed [ZW-1:0]  zr;
  logic signed [AngW-1:0] base, ang;
  logic [CoordW-1:0]     fx, fy;

  logic                   out_valid_r, out_touch_r;
  logic [CoordW-1:0]      out_x_r, out_y_r;
  logic signed [AngW-1:0] out_ang_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  assign x1 = in_tdata[15:0];
  assign y1 = in_tdata[31:16];
  assign r1 = in_tdata[47:32];
  assign x2 = in_tdata[63:48];
  assign y2 = in_tdata[79:64];
  assign r2 = in_tdata[95:80];
  assign mg = in_tdata[111:96];
  assign dx = $signed({1'b0, x2}) - $signed({1'b0, x1});
  assign dy = $signed({1'b0, y1}) - $signed({1'b0, y2});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r   <= in_tvalid;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      out_valid_r <= pipe_valid[NumSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x1_r       <= x1;
      a_y1_r       <= y1;
      a_x2_r       <= x2;
      a_y2_r       <= y2;
      a_r1_r       <= r1;
      a_r2_r       <= r2;
      a_adx_r      <= dx[CoordW] ? CoordW'(-dx) : CoordW'(dx);
      a_ady_r      <= dy[CoordW] ? CoordW'(-dy) : CoordW'(dy);
      a_dx_zero_r  <= (dx == '0);
      a_dx_pos_r   <= !dx[CoordW] && (dx != '0);
      a_sign_neg_r <= (dx[CoordW] != dy[CoordW]) && (dy != '0);
      a_y1_lt_r    <= (y1 < y2);
      a_total_r    <= TotW'(r1) + TotW'(r2);
      a_reach_r    <= (TotW+1)'(r1) + (TotW+1)'(r2) + (TotW+1)'(mg);

      b_d2a_r      <= 32'(a_adx_r) * 32'(a_adx_r);
      b_d2b_r      <= 32'(a_ady_r) * 32'(a_ady_r);
      b_reach2_r   <= 36'(a_reach_r) * 36'(a_reach_r);
      b_px_r       <= 32'(a_x2_r) * 32'(a_r1_r);
      b_qx_r       <= 32'(a_x1_r) * 32'(a_r2_r);
      b_py_r       <= 32'(a_y2_r) * 32'(a_r1_r);
      b_qy_r       <= 32'(a_y1_r) * 32'(a_r2_r);
      b_x1_r       <= a_x1_r;
      b_y1_r       <= a_y1_r;
      b_adx_r      <= a_adx_r;
      b_ady_r      <= a_ady_r;
      b_dx_zero_r  <= a_dx_zero_r;
      b_dx_pos_r   <= a_dx_pos_r;
      b_sign_neg_r <= a_sign_neg_r;
      b_y1_lt_r    <= a_y1_lt_r;
      b_total_r    <= a_total_r;

      c_data_r     <= c_data_nxt;
    end
  end

  always_comb begin
    c_data_nxt            = '0;
    c_data_nxt.touch      = (33'(b_d2a_r) + 33'(b_d2b_r)) <= b_reach2_r;
    c_data_nxt.zero_total = (b_total_r == '0);
    c_data_nxt.dx_zero    = b_dx_zero_r;
    c_data_nxt.dx_pos     = b_dx_pos_r;
    c_data_nxt.sign_neg   = b_sign_neg_r;
    c_data_nxt.y1_lt      = b_y1_lt_r;
    c_data_nxt.x1         = b_x1_r;
    c_data_nxt.y1         = b_y1_r;
    c_data_nxt.total      = b_total_r;
    // Rounded division: bias the numerator by half the divisor.
    c_data_nxt.rem_x      = RemW'(b_px_r) + RemW'(b_qx_r) + RemW'(b_total_r >> 1);
    c_data_nxt.rem_y      = RemW'(b_py_r) + RemW'(b_qy_r) + RemW'(b_total_r >> 1);
    c_data_nxt.cx         = $signed(CordW'(b_adx_r) << PreShift);
    c_data_nxt.cy         = $signed(CordW'(b_ady_r) << PreShift);
  end

  assign pipe_valid[0] = c_valid_r;
  assign pipe_data[0]  = c_data_r;

  for (genvar i = 0; i < NumSteps; i++) begin : g_iter
    ccc_iter_stage #(.STEP(i)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (pipe_valid[i]),
      .in_data   (pipe_data[i]),
      .out_valid (pipe_valid[i+1]),
      .out_data  (pipe_data[i+1])
    );
  end

  assign fin = pipe_data[NumSteps];

  always_comb begin
    if (fin.z < 0) begin
      zc = '0;
    end else if (fin.z > Deg90Q16) begin
      zc = Deg90Q16;
    end else begin
      zc = fin.z;
    end
    zr = (zc + RoundQ16) >>> 12;
    if (zr > ZW'(DegQ4_90)) begin
      base = DegQ4_90;
    end else begin
      base = AngW'(zr);
    end

    if (fin.sign_neg) begin
      ang = -base;
    end else begin
      ang = base;
    end
    if (fin.dx_pos) begin
      ang = ang + DegQ4_180;
    end
    if (fin.dx_zero) begin
      ang = fin.y1_lt ? DegQ4_270 : DegQ4_90;
    end

    fx = fin.q_x;
    fy = fin.q_y;
    // Not touching, or both radii zero: report the first centre and no angle.
    if (!fin.touch || fin.zero_total) begin
      fx  = fin.x1;
      fy  = fin.y1;
      ang = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_touch_r <= fin.touch;
      out_x_r     <= fx;
      out_y_r     <= fy;
      out_ang_r   <= ang;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_touch_r;
  assign out_tdata  = {2'b00, out_ang_r, out_y_r, out_x_r};

  a_no_touch_no_angle : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[45:32] == '0)
    else $error("angle reported for circles that do not touch");

  a_angle_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $signed(out_tdata[45:32]) >= -DegQ4_90 &&
                   $signed(out_tdata[45:32]) <= DegQ4_270)
    else $error("contact angle out of range");

  a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while output stalled");

endmodule

/* tb/circle_collision_contact_checker.sv */
// Result checker for the circle collision contact pipeline: predicts each result and compares.
module circle_collision_contact_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [111:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [47:0]  out_tdata,
  input  logic         out_tuser,
  output int           fail_count,
  output int           pending_count
);
  import ccc_pkg::*;

  typedef struct packed {
    logic              touching;
    logic [15:0]       contact_x;
    logic [15:0]       contact_y;
    logic [AngW-1:0]   contact_angle;
  } contact_t;

  contact_t contact_q[$];

  function automatic longint trunc_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v) >>> s);
  endfunction

  // Vectoring CORDIC for atan(ny/nx), degrees Q4, result 0..90 degrees.
  function automatic longint atan_q4(longint nx, longint ny);
    longint x, y, z, xs, ys;
    x = nx << PreShift;
    y = ny << PreShift;
    z = 0;
    for (int i = 0; i < NumSteps; i++) begin
      xs = trunc_shift(x, i);
      ys = trunc_shift(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + AtanTab[i];
      end else begin
        x = x - ys; y = y + xs; z = z - AtanTab[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 5898240) z = 5898240;
    z = (z + 2048) >>> 12;
    if (z > 1440) z = 1440;
    return z;
  endfunction

  function automatic contact_t predict_contact(logic [111:0] d);
    longint x1, y1, r1, x2, y2, r2, mg, dx, dy, adx, ady, reach, total, ang;
    contact_t c;
    x1 = d[15:0];  y1 = d[31:16]; r1 = d[47:32];
    x2 = d[63:48]; y2 = d[79:64]; r2 = d[95:80]; mg = d[111:96];
    dx = x2 - x1;
    dy = y1 - y2;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    reach = r1 + r2 + mg;
    total = r1 + r2;
    c.touching = (adx * adx + ady * ady) <= reach * reach;
    c.contact_x = x1[15:0];
    c.contact_y = y1[15:0];
    ang = 0;
    if (c.touching && total != 0) begin
      c.contact_x = 16'((x2 * r1 + x1 * r2 + total / 2) / total);
      c.contact_y = 16'((y2 * r1 + y1 * r2 + total / 2) / total);
      if (dx == 0) begin
        ang = (y1 < y2) ? 4320 : 1440;
      end else begin
        ang = atan_q4(adx, ady);
        if (((dx < 0) != (dy < 0)) && dy != 0) ang = -ang;
        if (dx > 0) ang = ang + 2880;
      end
    end
    c.contact_angle = AngW'(ang);
    return c;
  endfunction

  assign pending_count = contact_q.size();

  always @(posedge clk) begin
    contact_t got, want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready) contact_q = {contact_q, predict_contact(in_tdata)};
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[15:0], out_tdata[31:16], out_tdata[45:32]};
        if (contact_q.size() == 0) begin
          if (fail_count < 10) $display("result with no request waiting: %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = contact_q.pop_front();
          if (got !== want || out_tdata[47:46] !== 2'b00) begin
            if (fail_count < 10)
              $display("mismatch: want t=%b x=%h y=%h a=%0d, got t=%b x=%h y=%h a=%0d",
                       want.touching, want.contact_x, want.contact_y,
                       $signed(want.contact_angle), got.touching, got.contact_x,
                       got.contact_y, $signed(got.contact_angle));
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* tb/testbench.sv */
// Stimulus and verdict for the circle collision contact pipeline.
module testbench;
  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [47:0]  out_tdata;
  logic         out_tuser;
  int           fail_count;
  int           pending_count;
  int           cycle_count;

  circle_collision_contact_top DUT (.*);
  circle_collision_contact_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // Receiver stalls, with long stretches of always-ready.
  initial begin
    int gap;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_tready = 1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      gap = ($urandom_range(0, 2) == 0) ? 0 : pick_gap();
      if (gap > 0) begin
        out_tready = 0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 200000) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  task automatic send_request(logic [111:0] d);
    int gap;
    gap = ($urandom_range(0, 4) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [111:0] pack_circles(int x1, int y1, int r1, int x2, int y2,
                                                int r2, int mg);
    return {16'(mg), 16'(r2), 16'(y2), 16'(x2), 16'(r1), 16'(y1), 16'(x1)};
  endfunction

  // Mostly nearby pairs so that touching and the angle path get exercised.
  function automatic logic [111:0] random_pair();
    int x1, y1, x2, y2, span;
    if ($urandom_range(0, 4) == 0) return {$urandom, $urandom, $urandom, 16'($urandom)};
    span = ($urandom_range(0, 1) == 0) ? 64 : 4000;
    x1 = $urandom_range(0, 65535);
    y1 = $urandom_range(0, 65535);
    x2 = x1 + $urandom_range(0, 2 * span) - span;
    y2 = y1 + $urandom_range(0, 2 * span) - span;
    if ($urandom_range(0, 9) == 0) x2 = x1;
    if ($urandom_range(0, 9) == 0) y2 = y1;
    if (x2 < 0 || x2 > 65535) x2 = x1;
    if (y2 < 0 || y2 > 65535) y2 = y1;
    return pack_circles(x1, y1, $urandom_range(0, 3000), x2, y2, $urandom_range(0, 3000),
                        $urandom_range(0, 200));
  endfunction

  initial begin
    in_tvalid = 0;
    in_tdata  = '0;
    rst_n     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    send_request('0);
    send_request('1);
    send_request(pack_circles(100, 100, 0, 100, 100, 0, 0));
    send_request(pack_circles(1000, 1000, 50, 1000, 1080, 50, 0));
    send_request(pack_circles(1000, 1080, 50, 1000, 1000, 50, 0));
    send_request(pack_circles(1000, 1000, 50, 1090, 1000, 50, 0));
    send_request(pack_circles(1000, 1000, 50, 910, 1000, 50, 0));
    send_request(pack_circles(1000, 1000, 50, 1060, 1060, 50, 0));
    send_request(pack_circles(1000, 1000, 50, 940, 940, 50, 0));
    send_request(pack_circles(1000, 1000, 50, 1060, 940, 50, 0));
    send_request(pack_circles(1000, 1000, 50, 940, 1060, 50, 0));
    send_request(pack_circles(0, 0, 10, 65535, 65535, 10, 65535));
    send_request(pack_circles(0, 0, 10, 65535, 65535, 10, 0));
    send_request(pack_circles(65535, 0, 65535, 0, 65535, 65535, 65535));
    send_request(pack_circles(500, 500, 0, 510, 500, 0, 10));
    send_request(pack_circles(500, 500, 0, 510, 500, 0, 9));
    send_request(pack_circles(500, 500, 1, 505, 503, 65535, 0));
    send_request(pack_circles(0, 65535, 30000, 65535, 0, 30000, 40000));
    repeat (600) send_request(random_pair());
    in_tvalid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
